// ===== hdl/vspb_pkg.sv =====
// Package for the view synthesis pixel blender: beat types, register codes,
// sequencer states and the constant function that builds the 2^x table.
// No dependencies.
package vspb_pkg;

	localparam int COLOR_BITS          = 10;
	localparam int EXP_TABLE_DEPTH_DEF = 256;
	localparam int W_BITS              = 24;
	localparam int DIV_Q_BITS          = 17;
	localparam int DEN_BITS            = 33;
	localparam int EXPA_BITS           = 37;
	localparam int EXPA_SPLIT          = 20;
	localparam int M_BITS              = 30;
	localparam int MUL_BITS            = 25;

	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [63:0] LN2_Q32    = 64'd2977044472;
	localparam logic [23:0] WEIGHT_MAX = 24'hFFFFFF;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [16:0] SKIP_LIMIT = 17'd656;

	localparam logic [15:0] RAY_GAIN_RST     = 16'd2560;
	localparam logic [15:0] DEPTH_GAIN_RST   = 16'd12800;
	localparam logic [15:0] STRETCH_GAIN_RST = 16'd2560;
	localparam logic [15:0] MAX_STRETCH_RST  = 16'd20480;

	typedef enum logic [1:0] {
		CFG_RAY_ANGLE_GAIN  = 2'd0,
		CFG_DEPTH_GAIN      = 2'd1,
		CFG_STRETCHING_GAIN = 2'd2,
		CFG_MAX_STRETCH     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] ray_angle_gain;
		logic [15:0] depth_gain;
		logic [15:0] stretching_gain;
		logic [15:0] max_stretch;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
		logic [15:0] norm_disp;
		logic [15:0] ray_angle;
		logic [15:0] stretching;
		logic        first_candidate;
		logic        last_candidate;
	} cand_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] out_red;
		logic [COLOR_BITS-1:0] out_green;
		logic [COLOR_BITS-1:0] out_blue;
		logic [15:0] out_disp;
		logic [23:0] out_weight;
		logic [15:0] out_stretch;
	} pix_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WA, ST_WS, ST_WSUM, ST_XLO, ST_XHI, ST_XFIN, ST_XROM,
		ST_WDONE, ST_DMUL, ST_DSET, ST_DEN, ST_DEN2, ST_DIV,
		ST_BLA, ST_BLB, ST_BLC, ST_WAM, ST_WAS, ST_WBM, ST_WBS, ST_OUT
	} state_t;

	// round(65536 * e^x), x in Q.32, by a series up to the x^24 term
	function automatic logic [16:0] pow2_entry(input logic [63:0] x);
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [127:0] prod;
		term = 64'd1 << 32;
		sum  = term;
		for (int n = 1; n <= 24; n++) begin
			prod = 128'(term) * 128'(x);
			term = 64'(prod >> 32) / 64'(n);
			sum  = sum + term;
		end
		return 17'((sum + 64'd32768) >> 16);
	endfunction

endpackage

// ===== hdl/vspb_if.sv =====
// Valid/ready channel interfaces for candidate beats and result beats.
// Depends on vspb_pkg.
interface vspb_in_if;
	logic          valid;
	logic          ready;
	vspb_pkg::cand_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vspb_out_if;
	logic             valid;
	logic             ready;
	vspb_pkg::pix_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/vspb_mul.sv =====
// Shared unsigned multiplier with registered product.
// Depends on vspb_pkg.
module vspb_mul (
	input  logic                              clk,
	input  logic [vspb_pkg::MUL_BITS-1:0]     a,
	input  logic [vspb_pkg::MUL_BITS-1:0]     b,
	output logic [2*vspb_pkg::MUL_BITS-1:0]   p_q
);
	always_ff @(posedge clk) begin
		p_q <= (2*vspb_pkg::MUL_BITS)'(a) * (2*vspb_pkg::MUL_BITS)'(b);
	end
endmodule

// ===== hdl/vspb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the front weight ratio.
// Depends on vspb_pkg.
module vspb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [vspb_pkg::W_BITS-1:0]       num_w,
	input  logic [vspb_pkg::DEN_BITS-1:0]     den,
	output logic                              done_q,
	output logic [vspb_pkg::DIV_Q_BITS-1:0]   quot_q
);
	localparam int QB = vspb_pkg::DIV_Q_BITS;
	localparam int DB = vspb_pkg::DEN_BITS;
	localparam int CB = $clog2(QB + 1);

	logic [DB-1:0] rem_q;
	logic [QB-1:0] bits_q;
	logic [DB-1:0] den_q;
	logic [CB-1:0] cnt_q;
	logic [DB:0]   shifted;
	logic [DB:0]   trial;

	assign shifted = {rem_q, bits_q[QB-1]};
	assign trial   = shifted - (DB+1)'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CB'(QB);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CB'(1));
			end
		end
	end

	// dividend is num_w << 16; its top bits already sit below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DB'(num_w[vspb_pkg::W_BITS-1:1]);
			bits_q <= {num_w[0], (QB-1)'(0)};
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			bits_q <= {bits_q[QB-2:0], 1'b0};
			if (!trial[DB]) begin
				rem_q  <= trial[DB-1:0];
				quot_q <= {quot_q[QB-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DB-1:0];
				quot_q <= {quot_q[QB-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== hdl/vspb_exp.sv =====
// Power-of-two unit: table lookup of the fraction and shift by the integer
// part, giving a saturated Q8.16 weight. Depends on vspb_pkg.
module vspb_exp #(
	parameter int EXP_TABLE_DEPTH = vspb_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                          neg,
	input  logic [vspb_pkg::M_BITS-1:0]   m,
	output logic [vspb_pkg::W_BITS-1:0]   e
);
	localparam int IW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
	localparam int PW = 16 + IW + 1;
	localparam int QW = vspb_pkg::M_BITS - 16;

	logic [16:0] rom [EXP_TABLE_DEPTH];

	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] X =
			(64'(k) * vspb_pkg::LN2_Q32) / 64'(EXP_TABLE_DEPTH);
		assign rom[k] = vspb_pkg::pow2_entry(X);
	end

	logic [QW-1:0] q;
	logic [15:0]   r;
	logic [QW:0]   qn;
	logic [15:0]   rsel;
	logic [PW-1:0] prod;
	logic [IW-1:0] idx;
	logic [16:0]   ent;

	always_comb begin
		q    = m[vspb_pkg::M_BITS-1:16];
		r    = m[15:0];
		qn   = (QW+1)'(q) + (QW+1)'(r != 16'd0);
		rsel = (neg && r != 16'd0) ? (16'd0 - r) : r;
		prod = PW'(rsel) * PW'(EXP_TABLE_DEPTH);
		idx  = prod[16 +: IW];
		ent  = rom[idx];
		if (!neg) begin
			if (q >= QW'(8))
				e = vspb_pkg::WEIGHT_MAX;
			else
				e = 24'(ent) << q[2:0];
		end else begin
			if (qn >= (QW+1)'(24))
				e = '0;
			else
				e = 24'(ent) >> qn[4:0];
		end
	end
endmodule

// ===== hdl/vspb_core.sv =====
// Sequencer and accumulator: runs weight, depth factor, ratio and blend
// steps through the shared multiplier, divider and power-of-two unit.
// Depends on vspb_pkg, vspb_mul, vspb_div, vspb_exp.
module vspb_core #(
	parameter int EXP_TABLE_DEPTH = vspb_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vspb_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vspb_pkg::cand_t      in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vspb_pkg::pix_out_t   out_data
);
	localparam int COLOR_BITS = vspb_pkg::COLOR_BITS;
	localparam int MB = vspb_pkg::MUL_BITS;
	localparam int WB = vspb_pkg::W_BITS;
	localparam int EB = vspb_pkg::EXPA_BITS;
	localparam int ES = vspb_pkg::EXPA_SPLIT;

	vspb_pkg::state_t state_q, state_d, ret_q;

	logic [COLOR_BITS-1:0] c_c_q [3];
	logic [COLOR_BITS-1:0] a_c_q [3];
	logic [COLOR_BITS-1:0] n_c_q [3];
	logic [15:0] c_disp_q, c_st_q, c_ang_q;
	logic [15:0] a_disp_q, a_st_q;
	logic [15:0] n_disp_q, n_st_q;
	logic [WB-1:0] c_w_q, a_w_q, e_q;
	logic last_q, neg_q, afront_q;
	logic [15:0] dfrom_q, dto_q;
	logic [33:0] t_q;
	logic [EB-1:0] expa_q;
	logic [EB-1:0] macc_q;
	logic [vspb_pkg::M_BITS-1:0] m_q;
	logic [16:0] wa_q, wb_q;
	logic [2:0]  fi_q;
	logic [33:0] s_q;
	logic [31:0] wsum_q;

	logic [MB-1:0] mul_a, mul_b;
	logic [2*MB-1:0] p_q;
	logic div_start, div_done;
	logic [vspb_pkg::DIV_Q_BITS-1:0] quot;
	logic [WB-1:0] e_comb;
	logic [WB-1:0] front_w, back_w;
	logic [vspb_pkg::DEN_BITS-1:0] denom;
	logic [15:0] diff;
	logic [15:0] fa, fb;
	logic [33:0] mixv;
	logic [16:0] wk;
	logic [32:0] wtot;
	logic [EB+20:0] msum;
	logic pix_ok;

	vspb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(p_q));

	vspb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num_w(front_w),
		.den(denom), .done_q(div_done), .quot_q(quot)
	);

	vspb_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp (
		.neg(neg_q), .m(m_q), .e(e_comb)
	);

	always_comb begin
		front_w = afront_q ? a_w_q : c_w_q;
		back_w  = afront_q ? c_w_q : a_w_q;
		denom   = vspb_pkg::DEN_BITS'(front_w) + vspb_pkg::DEN_BITS'(p_q[47:16]);
		diff    = (dfrom_q >= dto_q) ? (dfrom_q - dto_q) : (dto_q - dfrom_q);
		wk      = vspb_pkg::ONE_Q16 - quot;
		mixv    = s_q + p_q[33:0] + 34'd32768;
		wtot    = 33'(wsum_q) + 33'(p_q[47:16]);
		msum    = (EB+21)'(macc_q) + ((EB+21)'(p_q[EB-ES-1+17:0]) << ES);
		pix_ok  = (a_w_q != '0) && (a_st_q < cfg.max_stretch);
		case (fi_q)
			3'd0:    begin fa = a_disp_q;        fb = c_disp_q;        end
			3'd1:    begin fa = a_st_q;          fb = c_st_q;          end
			3'd2:    begin fa = 16'(a_c_q[0]);   fb = 16'(c_c_q[0]);   end
			3'd3:    begin fa = 16'(a_c_q[1]);   fb = 16'(c_c_q[1]);   end
			default: begin fa = 16'(a_c_q[2]);   fb = 16'(c_c_q[2]);   end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		unique case (state_q)
			vspb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = vspb_pkg::ST_WA;
			end
			vspb_pkg::ST_WA: begin
				mul_a   = MB'(cfg.ray_angle_gain);
				mul_b   = MB'(c_ang_q);
				state_d = vspb_pkg::ST_WS;
			end
			vspb_pkg::ST_WS: begin
				mul_a   = MB'(cfg.stretching_gain);
				mul_b   = MB'(c_st_q);
				state_d = vspb_pkg::ST_WSUM;
			end
			vspb_pkg::ST_WSUM: state_d = vspb_pkg::ST_XLO;
			vspb_pkg::ST_XLO: begin
				mul_a   = MB'(expa_q[ES-1:0]);
				mul_b   = MB'(vspb_pkg::LOG2E_Q16);
				state_d = vspb_pkg::ST_XHI;
			end
			vspb_pkg::ST_XHI: begin
				mul_a   = MB'(expa_q[EB-1:ES]);
				mul_b   = MB'(vspb_pkg::LOG2E_Q16);
				state_d = vspb_pkg::ST_XFIN;
			end
			vspb_pkg::ST_XFIN: state_d = vspb_pkg::ST_XROM;
			vspb_pkg::ST_XROM: state_d = ret_q;
			vspb_pkg::ST_WDONE: begin
				if (a_w_q == '0 || e_q == '0)
					state_d = vspb_pkg::ST_OUT;
				else
					state_d = vspb_pkg::ST_DMUL;
			end
			vspb_pkg::ST_DMUL: begin
				mul_a   = MB'(cfg.depth_gain);
				mul_b   = MB'(diff);
				state_d = vspb_pkg::ST_DSET;
			end
			vspb_pkg::ST_DSET: state_d = vspb_pkg::ST_XLO;
			vspb_pkg::ST_DEN: begin
				mul_a   = MB'(back_w);
				mul_b   = MB'(e_q);
				state_d = vspb_pkg::ST_DEN2;
			end
			vspb_pkg::ST_DEN2: begin
				div_start = 1'b1;
				state_d   = vspb_pkg::ST_DIV;
			end
			vspb_pkg::ST_DIV: begin
				if (div_done)
					state_d = (wk < vspb_pkg::SKIP_LIMIT) ? vspb_pkg::ST_OUT
						: vspb_pkg::ST_BLA;
			end
			vspb_pkg::ST_BLA: begin
				mul_a   = MB'(wa_q);
				mul_b   = MB'(fa);
				state_d = vspb_pkg::ST_BLB;
			end
			vspb_pkg::ST_BLB: begin
				mul_a   = MB'(wb_q);
				mul_b   = MB'(fb);
				state_d = vspb_pkg::ST_BLC;
			end
			vspb_pkg::ST_BLC: begin
				state_d = (fi_q == 3'd4) ? vspb_pkg::ST_DMUL : vspb_pkg::ST_BLA;
			end
			vspb_pkg::ST_WAM: begin
				mul_a   = MB'(a_w_q);
				mul_b   = MB'(e_q);
				state_d = vspb_pkg::ST_WAS;
			end
			vspb_pkg::ST_WAS: state_d = vspb_pkg::ST_DMUL;
			vspb_pkg::ST_WBM: begin
				mul_a   = MB'(c_w_q);
				mul_b   = MB'(e_q);
				state_d = vspb_pkg::ST_WBS;
			end
			vspb_pkg::ST_WBS: state_d = vspb_pkg::ST_OUT;
			vspb_pkg::ST_OUT: begin
				if (!last_q || !out_valid || out_ready)
					state_d = vspb_pkg::ST_IDLE;
			end
			default: state_d = vspb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vspb_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// accumulator, return state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q     <= vspb_pkg::ST_IDLE;
			out_valid <= 1'b0;
			a_w_q     <= '0;
			a_disp_q  <= '0;
			a_st_q    <= '0;
			for (int i = 0; i < 3; i++)
				a_c_q[i] <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				vspb_pkg::ST_IDLE: begin
					if (in_valid && in_data.first_candidate) begin
						a_w_q    <= '0;
						a_disp_q <= '0;
						a_st_q   <= '0;
						for (int i = 0; i < 3; i++)
							a_c_q[i] <= '0;
					end
				end
				vspb_pkg::ST_WSUM: ret_q <= vspb_pkg::ST_WDONE;
				vspb_pkg::ST_WDONE: begin
					ret_q <= vspb_pkg::ST_DEN;
					if (a_w_q == '0) begin
						a_w_q    <= e_q;
						a_disp_q <= c_disp_q;
						a_st_q   <= c_st_q;
						for (int i = 0; i < 3; i++)
							a_c_q[i] <= c_c_q[i];
					end
				end
				vspb_pkg::ST_DIV: begin
					if (div_done && wk < vspb_pkg::SKIP_LIMIT && !afront_q) begin
						a_w_q    <= c_w_q;
						a_disp_q <= c_disp_q;
						a_st_q   <= c_st_q;
						for (int i = 0; i < 3; i++)
							a_c_q[i] <= c_c_q[i];
					end
				end
				vspb_pkg::ST_BLC: ret_q <= vspb_pkg::ST_WAM;
				vspb_pkg::ST_WAS: ret_q <= vspb_pkg::ST_WBM;
				vspb_pkg::ST_WBS: begin
					a_w_q    <= (wtot > 33'(vspb_pkg::WEIGHT_MAX)) ? vspb_pkg::WEIGHT_MAX
						: wtot[WB-1:0];
					a_disp_q <= n_disp_q;
					a_st_q   <= n_st_q;
					for (int i = 0; i < 3; i++)
						a_c_q[i] <= n_c_q[i];
				end
				vspb_pkg::ST_OUT: begin
					if (last_q && (!out_valid || out_ready)) begin
						out_valid <= 1'b1;
						out_data.out_red     <= pix_ok ? a_c_q[0] : '0;
						out_data.out_green   <= pix_ok ? a_c_q[1] : '0;
						out_data.out_blue    <= pix_ok ? a_c_q[2] : '0;
						out_data.out_disp    <= pix_ok ? a_disp_q : '0;
						out_data.out_weight  <= pix_ok ? a_w_q : '0;
						out_data.out_stretch <= pix_ok ? a_st_q : '0;
					end
				end
				default: ;
			endcase
		end
	end

	// candidate and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			vspb_pkg::ST_IDLE: begin
				if (in_valid) begin
					c_c_q[0] <= in_data.red;
					c_c_q[1] <= in_data.green;
					c_c_q[2] <= in_data.blue;
					c_disp_q <= in_data.norm_disp;
					c_st_q   <= in_data.stretching;
					c_ang_q  <= in_data.ray_angle;
					last_q   <= in_data.last_candidate;
				end
			end
			vspb_pkg::ST_WS: t_q <= p_q[33:0];
			vspb_pkg::ST_WSUM: begin
				expa_q <= (EB'(t_q) << 2) + (EB'(p_q[31:0]) << 4);
				neg_q  <= 1'b1;
			end
			vspb_pkg::ST_XHI: macc_q <= p_q[EB-1:0];
			vspb_pkg::ST_XFIN: m_q <= vspb_pkg::M_BITS'(msum >> 24);
			vspb_pkg::ST_XROM: e_q <= e_comb;
			vspb_pkg::ST_WDONE: begin
				c_w_q    <= e_q;
				afront_q <= (a_disp_q >= c_disp_q);
				dfrom_q  <= (a_disp_q >= c_disp_q) ? c_disp_q : a_disp_q;
				dto_q    <= (a_disp_q >= c_disp_q) ? a_disp_q : c_disp_q;
			end
			vspb_pkg::ST_DMUL: neg_q <= (dfrom_q < dto_q);
			vspb_pkg::ST_DSET: expa_q <= EB'(p_q[31:0]);
			vspb_pkg::ST_DIV: begin
				wa_q <= afront_q ? quot : wk;
				wb_q <= afront_q ? wk : quot;
				fi_q <= '0;
			end
			vspb_pkg::ST_BLB: s_q <= p_q[33:0];
			vspb_pkg::ST_BLC: begin
				fi_q <= fi_q + 3'd1;
				case (fi_q)
					3'd0:    n_disp_q <= mixv[31:16];
					3'd1:    n_st_q   <= mixv[31:16];
					3'd2:    n_c_q[0] <= COLOR_BITS'(mixv[31:16]);
					3'd3:    n_c_q[1] <= COLOR_BITS'(mixv[31:16]);
					default: n_c_q[2] <= COLOR_BITS'(mixv[31:16]);
				endcase
				dfrom_q <= a_disp_q;
				dto_q   <= (fi_q == 3'd0) ? mixv[31:16] : n_disp_q;
			end
			vspb_pkg::ST_WAS: begin
				wsum_q  <= p_q[47:16];
				dfrom_q <= c_disp_q;
				dto_q   <= n_disp_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/view_synthesis_pixel_blender.sv =====
// Top level of the view synthesis pixel blender: configuration registers
// and channel hookup. Depends on vspb_pkg, vspb_if, vspb_core.
//
//  channel  dir  beat       notes
//  in_ch    in   cand_t     one candidate pixel
//  out_ch   out  pix_out_t  one blended pixel, on last_candidate only
//  cfg_*    in   16 bits    write-only registers, index 0..3
//
// A candidate ends soonest when the accumulator is empty or the candidate's
// weight is zero, later when the back weight is dropped and last for a full
// blend, using the 17-step divider and up to four passes through the shared
// multiplier and 2^x table. Reset clears the accumulator; no clearing pass.
// in_ch.ready is high only between candidates; a result waiting on out_ch
// holds the next result back until out_ch takes it.
module view_synthesis_pixel_blender #(
	parameter int EXP_TABLE_DEPTH = vspb_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	vspb_in_if.sink       in_ch,
	vspb_out_if.source    out_ch,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	vspb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ray_angle_gain  <= vspb_pkg::RAY_GAIN_RST;
			cfg_q.depth_gain      <= vspb_pkg::DEPTH_GAIN_RST;
			cfg_q.stretching_gain <= vspb_pkg::STRETCH_GAIN_RST;
			cfg_q.max_stretch     <= vspb_pkg::MAX_STRETCH_RST;
		end else if (cfg_we) begin
			unique case (vspb_pkg::cfg_idx_t'(cfg_index))
				vspb_pkg::CFG_RAY_ANGLE_GAIN:  cfg_q.ray_angle_gain  <= cfg_data;
				vspb_pkg::CFG_DEPTH_GAIN:      cfg_q.depth_gain      <= cfg_data;
				vspb_pkg::CFG_STRETCHING_GAIN: cfg_q.stretching_gain <= cfg_data;
				vspb_pkg::CFG_MAX_STRETCH:     cfg_q.max_stretch     <= cfg_data;
				default: ;
			endcase
		end
	end

	vspb_core #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

// ===== hdl/vspb_checker.sv =====
// Port-level checks for the pixel blender, bound to the top level.
// Depends on vspb_pkg.
module vspb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input vspb_pkg::pix_out_t out_data
);
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a candidate is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result beat without candidate work");

	a_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_weight == '0 |->
			out_data.out_red == '0 && out_data.out_green == '0 &&
			out_data.out_blue == '0 && out_data.out_disp == '0 &&
			out_data.out_stretch == '0)
		else $error("invalid pixel not zeroed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");
endmodule

bind view_synthesis_pixel_blender vspb_checker u_vspb_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
